[hw/rtl/cds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg: shared types for the calendar date subtractor
// Payload structs for the request and response channels, field widths and
// the control bundle for the year split unit.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned STATUS_W = 2;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [FUNC_W-1:0]  func;
    logic [COUNT_W-1:0] count;
  } req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   new_year;
    logic [MONTH_W-1:0]  new_month;
    logic [DAY_W-1:0]    new_day;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // year split unit control: div loads year/100, rem loads year%100
  typedef struct packed {
    logic div_en;
    logic rem_en;
  } ysplit_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/cds_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_req_if: request channel of the calendar date subtractor
// Valid/ready handshake carrying the start date, operation and count.
// ----------------------------------------------------------------------------
interface cds_req_if;
  logic          valid;
  logic          ready;
  cds_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/cds_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_rsp_if: response channel of the calendar date subtractor
// Valid/ready handshake carrying the resulting date and status.
// ----------------------------------------------------------------------------
interface cds_rsp_if;
  logic          valid;
  logic          ready;
  cds_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/cds_year_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_year_split: splits a year into century and year-in-century
// Two-step shared unit: a reciprocal multiply gives year/100, then a
// constant multiply and subtract gives year%100. Leap flag follows from both.
// ----------------------------------------------------------------------------
module cds_year_split (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [cds_pkg::YEAR_W-1:0]  year_i,
  input  wire cds_pkg::ysplit_ctrl_t ctrl_i,
  output logic                       leap_o
);

  // floor(y*5243 / 2^19) == y/100 for every 14-bit y
  localparam int unsigned RECIP_W = 13;
  localparam int unsigned SHIFT   = 19;
  localparam int unsigned PROD_W  = cds_pkg::YEAR_W + RECIP_W;
  localparam int unsigned HI_W    = 8;   // 16383/100 = 163
  localparam int unsigned LO_W    = 7;
  localparam int unsigned HUND_W  = HI_W + LO_W;
  localparam logic [RECIP_W-1:0] RECIP   = 13'd5243;
  localparam logic [LO_W-1:0]    HUNDRED = 7'd100;

  logic [PROD_W-1:0] prod;
  logic [HUND_W-1:0] hund;
  logic [HUND_W-1:0] diff;
  logic [HI_W-1:0]   hi_q;
  logic [LO_W-1:0]   lo_q;

  assign prod = {{RECIP_W{1'b0}}, year_i} * {{cds_pkg::YEAR_W{1'b0}}, RECIP};
  assign hund = {{LO_W{1'b0}}, hi_q} * {{HI_W{1'b0}}, HUNDRED};
  assign diff = {1'b0, year_i} - hund;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      if (ctrl_i.div_en) begin
        hi_q <= prod[SHIFT +: HI_W];
      end
      if (ctrl_i.rem_en) begin
        lo_q <= diff[LO_W-1:0];
      end
    end
  end

  // 100 is a multiple of 4, so y%4 is lo%4; y%400==0 iff lo==0 and hi%4==0
  assign leap_o = (lo_q != '0) ? (lo_q[1:0] == 2'b00) : (hi_q[1:0] == 2'b00);

endmodule
`default_nettype wire

[hw/rtl/calendar_date_subtract.sv]
// Sequence: year split (div, rem), check, stepping states, done. Day, week and
// month requests take one step per day or month and rerun the year split each
// time a step crosses into the previous year; year, decade, century and
// millennium subtract at once, then rerun the split and fix Feb 29.
// Throughput: one request at a time; the longest request is 1023 weeks.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_subtract: Gregorian date subtraction
// Steps a date back by days, weeks, months, years, decades, one century or
// one millennium, with leap-aware clamping, and reports invalid input dates
// and underflow below year 0.
// ----------------------------------------------------------------------------
module calendar_date_subtract (
  input  wire         clk_i,
  input  wire         rst_ni,
  cds_req_if.sink     req_i,
  cds_rsp_if.source   rsp_o
);

  localparam int unsigned YW = cds_pkg::YEAR_W;
  localparam int unsigned MW = cds_pkg::MONTH_W;
  localparam int unsigned DW = cds_pkg::DAY_W;
  localparam int unsigned FW = cds_pkg::FUNC_W;
  localparam int unsigned SW = cds_pkg::STATUS_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DAY   = 4'd4;
  localparam logic [3:0] S_MON   = 4'd5;
  localparam logic [3:0] S_YEAR  = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [FW-1:0] FUNC_DAYS       = 3'd0;
  localparam logic [FW-1:0] FUNC_WEEKS      = 3'd1;
  localparam logic [FW-1:0] FUNC_MONTHS     = 3'd2;
  localparam logic [FW-1:0] FUNC_YEARS      = 3'd3;
  localparam logic [FW-1:0] FUNC_DECADES    = 3'd4;
  localparam logic [FW-1:0] FUNC_CENTURY    = 3'd5;
  localparam logic [FW-1:0] FUNC_MILLENNIUM = 3'd6;

  localparam logic [SW-1:0] STATUS_OK        = 2'd0;
  localparam logic [SW-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [SW-1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic [YW-1:0] YEAR_MAX        = 14'd9999;
  localparam logic [YW-1:0] YEARS_CENTURY   = 14'd100;
  localparam logic [YW-1:0] YEARS_MILLENNIUM = 14'd1000;

  localparam logic [MW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MW-1:0] MONTH_DEC = 4'd12;
  localparam logic [DW-1:0] DAY_28    = 5'd28;
  localparam logic [DW-1:0] DAY_29    = 5'd29;
  localparam logic [DW-1:0] DAY_31    = 5'd31;

  function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
    logic [DW-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? DAY_29 : DAY_28;
      default:                                     len = '0;
    endcase
    return len;
  endfunction

  logic [3:0]    state_q, state_d;
  logic [3:0]    ret_q, ret_d;
  logic [YW-1:0] y_q, y_d;
  logic [MW-1:0] m_q, m_d;
  logic [DW-1:0] d_q, d_d;
  logic [FW-1:0] fn_q, fn_d;
  logic [YW-1:0] iter_q, iter_d;   // step count, or years to subtract
  logic [SW-1:0] st_q, st_d;
  cds_pkg::req_t orig_q, orig_d;
  cds_pkg::rsp_t out_q;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  cds_pkg::ysplit_ctrl_t ys_ctrl;
  logic                  leap;
  logic [YW-1:0]         cnt;
  logic [DW-1:0]         len_cur;
  logic [DW-1:0]         len_prev;

  cds_year_split u_year_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .year_i (y_q),
    .ctrl_i (ys_ctrl),
    .leap_o (leap)
  );

  assign cnt      = {{(YW-cds_pkg::COUNT_W){1'b0}}, orig_q.count};
  assign len_cur  = month_len(m_q, leap);
  assign len_prev = month_len(m_q - MONTH_JAN, leap);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    y_d      = y_q;
    m_d      = m_q;
    d_d      = d_q;
    fn_d     = fn_q;
    iter_d   = iter_q;
    st_d     = st_q;
    orig_d   = orig_q;
    ys_ctrl  = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          orig_d  = req_i.payload;
          y_d     = req_i.payload.start_year;
          m_d     = req_i.payload.start_month;
          d_d     = req_i.payload.start_day;
          fn_d    = req_i.payload.func;
          st_d    = STATUS_OK;
          ret_d   = S_CHECK;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        ys_ctrl.div_en = 1'b1;
        state_d        = S_REM;
      end
      S_REM: begin
        ys_ctrl.rem_en = 1'b1;
        state_d        = ret_q;
      end
      S_CHECK: begin
        if (y_q > YEAR_MAX || m_q < MONTH_JAN || m_q > MONTH_DEC ||
            d_q == '0 || d_q > len_cur) begin
          st_d    = STATUS_INVALID;
          state_d = S_DONE;
        end else begin
          case (fn_q)
            FUNC_DAYS: begin
              iter_d  = cnt;
              state_d = S_DAY;
            end
            FUNC_WEEKS: begin
              iter_d  = (cnt << 3) - cnt;
              state_d = S_DAY;
            end
            FUNC_MONTHS: begin
              iter_d  = cnt;
              state_d = S_MON;
            end
            FUNC_YEARS: begin
              iter_d  = cnt;
              state_d = S_YEAR;
            end
            FUNC_DECADES: begin
              iter_d  = (cnt << 3) + (cnt << 1);
              state_d = S_YEAR;
            end
            FUNC_CENTURY: begin
              iter_d  = YEARS_CENTURY;
              state_d = S_YEAR;
            end
            FUNC_MILLENNIUM: begin
              iter_d  = YEARS_MILLENNIUM;
              state_d = S_YEAR;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DAY: begin
        if (iter_q == '0) begin
          state_d = S_DONE;
        end else if (d_q > 5'd1) begin
          d_d    = d_q - 5'd1;
          iter_d = iter_q - YW'(1);
        end else if (m_q > MONTH_JAN) begin
          m_d    = m_q - MONTH_JAN;
          d_d    = len_prev;
          iter_d = iter_q - YW'(1);
        end else if (y_q == '0) begin
          st_d    = STATUS_UNDERFLOW;
          state_d = S_DONE;
        end else begin
          // new year: refresh the leap flag before the next step
          y_d     = y_q - YW'(1);
          m_d     = MONTH_DEC;
          d_d     = DAY_31;
          iter_d  = iter_q - YW'(1);
          ret_d   = S_DAY;
          state_d = S_DIV;
        end
      end
      S_MON: begin
        if (iter_q == '0) begin
          state_d = S_DONE;
        end else if (m_q > MONTH_JAN) begin
          m_d    = m_q - MONTH_JAN;
          d_d    = (d_q > len_prev) ? len_prev : d_q;
          iter_d = iter_q - YW'(1);
        end else if (y_q == '0) begin
          st_d    = STATUS_UNDERFLOW;
          state_d = S_DONE;
        end else begin
          // December never clamps
          y_d     = y_q - YW'(1);
          m_d     = MONTH_DEC;
          iter_d  = iter_q - YW'(1);
          ret_d   = S_MON;
          state_d = S_DIV;
        end
      end
      S_YEAR: begin
        if (iter_q > y_q) begin
          st_d    = STATUS_UNDERFLOW;
          state_d = S_DONE;
        end else begin
          y_d     = y_q - iter_q;
          ret_d   = S_FIX;
          state_d = S_DIV;
        end
      end
      S_FIX: begin
        if (m_q == MONTH_FEB && d_q == DAY_29 && !leap) begin
          d_d = DAY_28;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_CHECK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    m_q    <= m_d;
    d_q    <= d_d;
    fn_q   <= fn_d;
    iter_q <= iter_d;
    st_q   <= st_d;
    orig_q <= orig_d;
    if (out_load) begin
      out_q.status <= st_q;
      if (st_q != STATUS_OK) begin
        out_q.new_year  <= orig_q.start_year;
        out_q.new_month <= orig_q.start_month;
        out_q.new_day   <= orig_q.start_day;
      end else begin
        out_q.new_year  <= y_q;
        out_q.new_month <= m_q;
        out_q.new_day   <= d_q;
      end
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

`ifndef SYNTHESIS
  a_accept_starts_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_DIV))
    else $error("accepted request did not start the year split");

  a_stepping_date_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DAY || state_q == S_MON) |->
      (d_q != '0 && m_q >= MONTH_JAN && m_q <= MONTH_DEC))
    else $error("working date left the valid range");

  a_year_never_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && $past(state_q) != S_IDLE) |-> (y_q <= $past(y_q)))
    else $error("working year increased during a request");

  a_ok_result_has_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.status == STATUS_OK) |-> (rsp_o.payload.new_day != '0))
    else $error("ok result carries day zero");
`endif

endmodule
`default_nettype wire
